FILE: rtl/core/wind_speed_window_stats_defines.svh
// ----------------------------------------------------------------------------
// Wind speed window statistics - assertion macros
// Concurrent assertion wrappers shared by the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef WIND_SPEED_WINDOW_STATS_DEFINES_SVH
`define WIND_SPEED_WINDOW_STATS_DEFINES_SVH

`ifndef ASSERT_OFF
`define WSS_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WSS_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define WSS_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WSS_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`define WSS_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons, msg)
`define WSS_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons, msg)
`endif

`endif

FILE: rtl/core/wss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind speed window statistics - package
// Field widths, action codes and transaction types shared across the block.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int WINDOW_DEF = 10;
  localparam int COUNT_W    = 16;
  localparam int PULSE_W    = 20;
  localparam int PEAK_W     = 17;
  localparam int AVG_W      = 23;
  localparam int GUST_W     = 24;
  localparam int CMDQ_DEPTH = 2;
  localparam int SPEED_MUL  = 200;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_MINUTE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    OP_START,
    OP_MINUTE,
    OP_QUERY
  } op_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [COUNT_W-1:0] counter_value;
  } in_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_sum;
    logic [PEAK_W-1:0]  pair_peak;
    logic [AVG_W-1:0]   avg_speed_centi;
    logic [GUST_W-1:0]  gust_speed_centi;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [COUNT_W-1:0] count;
  } cmd_t;

endpackage

FILE: rtl/core/wss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind speed window statistics - front end
// Accepts input transactions, decodes the action, drops unused codes and
// queues commands for the back end.
// ----------------------------------------------------------------------------
`include "wind_speed_window_stats_defines.svh"

module wss_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  wss_pkg::in_item_t in_data,
  output logic              in_full,
  output logic              cmd_valid,
  output wss_pkg::cmd_t     cmd,
  input  logic              cmd_ready
);

  localparam int DEPTH = wss_pkg::CMDQ_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wss_pkg::cmd_t    q_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  wss_pkg::op_t     dec_op;
  logic             dec_keep;
  logic             enq;
  logic             deq;

  always_comb begin
    dec_op   = wss_pkg::OP_START;
    dec_keep = 1'b1;
    case (in_data.action)
      wss_pkg::ACT_START:  dec_op = wss_pkg::OP_START;
      wss_pkg::ACT_MINUTE: dec_op = wss_pkg::OP_MINUTE;
      wss_pkg::ACT_QUERY:  dec_op = wss_pkg::OP_QUERY;
      default:             dec_keep = 1'b0;
    endcase
  end

  assign in_full   = (cnt_r == CNT_W'(DEPTH));
  assign enq       = in_push && !in_full && dec_keep;
  assign cmd_valid = (cnt_r != '0);
  assign deq       = cmd_valid && cmd_ready;
  assign cmd       = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr_r] <= '{op: dec_op, count: in_data.counter_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (enq) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (deq) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({enq, deq})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `WSS_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH), "command queue overflow")
  `WSS_ASSERT_NXT(a_drop_unused, clk, rst_n, in_push && !in_full && !dec_keep && !deq, cnt_r == $past(cnt_r), "unused action code was queued")

endmodule

FILE: rtl/core/wss_cdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind speed window statistics - constant divider
// Quotient by one of two constants: reciprocal multiply, back-multiply and a
// single correction step, one multiplier per stage.
// ----------------------------------------------------------------------------
`include "wind_speed_window_stats_defines.svh"

module wss_cdiv #(
  parameter int X_W   = 28,
  parameter int D_W   = 5,
  parameter int DIV_A = 30,
  parameter int DIV_B = 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           sel_b,
  input  logic [X_W-1:0] x,
  output logic           done,
  output logic [X_W-1:0] q
);

  localparam logic [63:0]    M_A64 = (64'd1 << X_W) / DIV_A;
  localparam logic [63:0]    M_B64 = (64'd1 << X_W) / DIV_B;
  localparam logic [X_W-1:0] M_A   = M_A64[X_W-1:0];
  localparam logic [X_W-1:0] M_B   = M_B64[X_W-1:0];
  localparam logic [D_W-1:0] D_A   = D_W'(DIV_A);
  localparam logic [D_W-1:0] D_B   = D_W'(DIV_B);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_QD,
    ST_FIX
  } st_t;

  st_t                st_r;
  logic               done_r;
  logic [X_W-1:0]     x_r;
  logic [X_W-1:0]     m_r;
  logic [D_W-1:0]     d_r;
  logic [2*X_W-1:0]   prod_r;
  logic [X_W-1:0]     q0_r;
  logic [X_W-1:0]     qd_r;
  logic [X_W-1:0]     q_r;
  logic [X_W-1:0]     rem;

  assign rem  = x_r - qd_r;
  assign done = done_r;
  assign q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == ST_FIX);
      case (st_r)
        ST_IDLE: begin
          if (start) begin
            x_r  <= x;
            m_r  <= sel_b ? M_B : M_A;
            d_r  <= sel_b ? D_B : D_A;
            st_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r <= {{X_W{1'b0}}, x_r} * {{X_W{1'b0}}, m_r};
          st_r   <= ST_QD;
        end
        ST_QD: begin
          q0_r <= prod_r[2*X_W-1:X_W];
          qd_r <= X_W'(prod_r[2*X_W-1:X_W] * d_r);
          st_r <= ST_FIX;
        end
        ST_FIX: begin
          q_r  <= (rem >= X_W'(d_r)) ? q0_r + 1'b1 : q0_r;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `WSS_ASSERT_IMP(a_rem_range, clk, rst_n, st_r == ST_FIX, rem < {d_r, 1'b0}, "reciprocal estimate off by more than one")

endmodule

FILE: rtl/core/wss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind speed window statistics - back end
// Executes start, minute and query commands against the slot store, walks
// the window one slot a cycle and holds the result register.
// ----------------------------------------------------------------------------
`include "wind_speed_window_stats_defines.svh"

module wss_back #(
  parameter int WINDOW = wss_pkg::WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  wss_pkg::cmd_t      cmd,
  output logic               cmd_ready,
  input  logic               out_pop,
  output logic               out_empty,
  output wss_pkg::out_item_t out_data
);

  localparam int CW     = wss_pkg::COUNT_W;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int IDX_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = CW + $clog2(WINDOW);
  localparam int X_W    = SUM_W + 8;
  localparam int SX_W   = (SUM_W > wss_pkg::PULSE_W) ? SUM_W : wss_pkg::PULSE_W;
  localparam int PW     = wss_pkg::PEAK_W;
  localparam int D_W    = $clog2(3 * WINDOW + 1);
  localparam logic [wss_pkg::PULSE_W-1:0] PULSE_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_AVG,
    S_AVG_W,
    S_GUST_W,
    S_OUT
  } state_t;

  state_t                      st_r;
  logic [CW-1:0]               store_mem [WINDOW];
  logic [WINDOW-1:0]           slot_vld_r;
  logic [SLOT_W-1:0]           wr_slot_r;
  logic [CW-1:0]               last_r;
  logic [CW-1:0]               rd_data_r;
  logic                        rd_vld_r;
  logic [IDX_W-1:0]            idx_r;
  logic [SUM_W-1:0]            sum_r;
  logic [PW-1:0]               peak_r;
  logic [CW-1:0]               prev_r;
  logic [wss_pkg::AVG_W-1:0]   avg_r;
  logic [wss_pkg::GUST_W-1:0]  gust_r;
  logic                        div_start_r;
  logic                        div_sel_r;
  logic [X_W-1:0]              div_x_r;
  logic                        out_vld_r;
  wss_pkg::out_item_t          out_data_r;

  logic                        take;
  logic                        mem_we;
  logic [CW-1:0]               diff;
  logic [SLOT_W-1:0]           rd_addr;
  logic [CW-1:0]               slot_val;
  logic [PW-1:0]               pair;
  logic [SX_W-1:0]             sum_x;
  logic [wss_pkg::PULSE_W-1:0] pulse_sat;
  logic                        div_done;
  logic [X_W-1:0]              div_q;

  assign cmd_ready = (st_r == S_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign mem_we    = take && (cmd.op == wss_pkg::OP_MINUTE);
  assign diff      = cmd.count - last_r;
  assign rd_addr   = (idx_r < IDX_W'(WINDOW)) ? idx_r[SLOT_W-1:0] : '0;
  assign slot_val  = rd_vld_r ? rd_data_r : '0;
  assign pair      = {1'b0, prev_r} + {1'b0, slot_val};
  assign sum_x     = SX_W'(sum_r);
  assign pulse_sat = (sum_x > SX_W'(PULSE_MAX)) ? PULSE_MAX : sum_x[wss_pkg::PULSE_W-1:0];
  assign out_empty = !out_vld_r;
  assign out_data  = out_data_r;

  wss_cdiv #(
    .X_W   (X_W),
    .D_W   (D_W),
    .DIV_A (3 * WINDOW),
    .DIV_B (3)
  ) u_cdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .sel_b (div_sel_r),
    .x     (div_x_r),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[wr_slot_r] <= diff;
    end
    rd_data_r <= store_mem[rd_addr];
    rd_vld_r  <= slot_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      slot_vld_r  <= '0;
      wr_slot_r   <= '0;
      last_r      <= '0;
      div_start_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      div_start_r <= (st_r == S_AVG) || (st_r == S_AVG_W && div_done);
      if (st_r == S_OUT && (!out_vld_r || out_pop)) begin
        out_vld_r <= 1'b1;
      end else if (out_pop && out_vld_r) begin
        out_vld_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (take) begin
            case (cmd.op)
              wss_pkg::OP_START: begin
                slot_vld_r <= '0;
                wr_slot_r  <= '0;
                last_r     <= cmd.count;
              end
              wss_pkg::OP_MINUTE: begin
                slot_vld_r[wr_slot_r] <= 1'b1;
                wr_slot_r <= (wr_slot_r == SLOT_W'(WINDOW - 1)) ? '0 : wr_slot_r + 1'b1;
                last_r    <= cmd.count;
              end
              wss_pkg::OP_QUERY: begin
                idx_r  <= '0;
                sum_r  <= '0;
                peak_r <= '0;
                st_r   <= S_WALK;
              end
              default: st_r <= S_IDLE;
            endcase
          end
        end
        S_WALK: begin
          // read data is registered, so it arrives the cycle after its address
          if (idx_r != '0) begin
            sum_r  <= sum_r + SUM_W'(slot_val);
            prev_r <= slot_val;
            if (idx_r >= IDX_W'(2) && pair > peak_r) begin
              peak_r <= pair;
            end
          end
          if (idx_r == IDX_W'(WINDOW)) begin
            st_r <= S_AVG;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_AVG: begin
          div_x_r   <= X_W'(sum_r) * X_W'(wss_pkg::SPEED_MUL);
          div_sel_r <= 1'b0;
          st_r      <= S_AVG_W;
        end
        S_AVG_W: begin
          if (div_done) begin
            avg_r     <= div_q[wss_pkg::AVG_W-1:0];
            div_x_r   <= X_W'(peak_r) * X_W'(wss_pkg::SPEED_MUL);
            div_sel_r <= 1'b1;
            st_r      <= S_GUST_W;
          end
        end
        S_GUST_W: begin
          if (div_done) begin
            gust_r <= div_q[wss_pkg::GUST_W-1:0];
            st_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_vld_r || out_pop) begin
            out_data_r.pulse_sum        <= pulse_sat;
            out_data_r.pair_peak        <= peak_r;
            out_data_r.avg_speed_centi  <= avg_r;
            out_data_r.gust_speed_centi <= gust_r;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `WSS_ASSERT_NXT(a_start_clears, clk, rst_n, take && cmd.op == wss_pkg::OP_START, slot_vld_r == '0 && wr_slot_r == '0, "start did not clear the window")
  `WSS_ASSERT(a_slot_range, clk, rst_n, IDX_W'(wr_slot_r) < IDX_W'(WINDOW), "write slot outside the window")

endmodule

FILE: rtl/core/wind_speed_window_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind speed window statistics - top level
// Keeps WINDOW per-minute anemometer pulse counts and reports the window sum,
// the largest neighbouring-slot pair and the average and gust speeds in
// hundredths of m/s. Input transactions enter a two-deep command queue, so
// the source can push while the back end is busy or a result waits. Start
// and minute transactions are executed in the back end's idle state. A query
// occupies the back end while it walks the slot store through its single
// registered read port, then makes two passes of the constant divider for
// the two speeds. The store is cleared through per-slot valid bits, so no
// clearing pass follows reset.
// ----------------------------------------------------------------------------

module wind_speed_window_stats #(
  parameter int WINDOW = wss_pkg::WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  wss_pkg::in_item_t  in_data,
  output logic               in_full,
  input  logic               out_pop,
  output logic               out_empty,
  output wss_pkg::out_item_t out_data
);

  logic          cmd_valid;
  logic          cmd_ready;
  wss_pkg::cmd_t cmd;

  wss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  wss_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind speed window statistics - testbench
// Directed then randomised start, minute and query transactions through the
// input queue. Every query result is checked field by field against a local
// model of the ten-slot pulse store, with random idling on both sides, a long
// receiver hold-off that fills the block, and a pause until all results land.
// ----------------------------------------------------------------------------

module tb;

  localparam int WIN = wss_pkg::WINDOW_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1350;

  typedef struct {
    wss_pkg::in_item_t item;
    bit                drain;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  wss_pkg::in_item_t  in_data = '0;
  logic               in_full;
  logic               out_pop = 1'b0;
  logic               out_empty;
  wss_pkg::out_item_t out_data;

  pending_t           pending[$];
  wss_pkg::out_item_t expected_stats[$];
  logic [15:0]        slot_counts[WIN];
  int unsigned        next_slot;
  logic [15:0]        prev_counter;

  int          items_sent = 0;
  int          total_items = 1;
  int          counted = 0;
  int          mismatches = 0;
  int unsigned phase = 0;
  logic        hold_off = 1'b0;
  int unsigned send_idle[3] = '{33, 74, 0};
  int unsigned recv_idle[3] = '{74, 33, 0};

  wind_speed_window_stats u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // advance the window model by one accepted transaction
  function automatic void apply_wind_item(input wss_pkg::in_item_t it);
    longint unsigned    sum;
    longint unsigned    peak;
    longint unsigned    pair;
    wss_pkg::out_item_t r;
    case (it.action)
      wss_pkg::ACT_START: begin
        foreach (slot_counts[i]) slot_counts[i] = '0;
        next_slot    = 0;
        prev_counter = it.counter_value;
      end
      wss_pkg::ACT_MINUTE: begin
        slot_counts[next_slot] = it.counter_value - prev_counter;
        next_slot    = (next_slot >= WIN - 1) ? 0 : next_slot + 1;
        prev_counter = it.counter_value;
      end
      wss_pkg::ACT_QUERY: begin
        sum  = slot_counts[0];
        peak = 0;
        for (int i = 1; i < WIN; i++) begin
          pair = longint'(slot_counts[i-1]) + longint'(slot_counts[i]);
          sum += slot_counts[i];
          if (pair > peak) peak = pair;
        end
        r.pulse_sum        = (sum > 64'hFFFFF) ? '1 : sum[wss_pkg::PULSE_W-1:0];
        r.pair_peak        = peak[wss_pkg::PEAK_W-1:0];
        r.avg_speed_centi  = wss_pkg::AVG_W'((sum * 200) / (3 * WIN));
        r.gust_speed_centi = wss_pkg::GUST_W'((peak * 200) / 3);
        expected_stats.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void add_item(input logic [1:0] act, input logic [15:0] cnt,
                                   input bit drain = 1'b0);
    pending_t p;
    p.item.action        = act;
    p.item.counter_value = cnt;
    p.drain              = drain;
    pending.push_back(p);
    if (act != ACT_UNUSED) counted++;
  endfunction

  // sender
  always @(posedge clk) begin : driver
    logic fire;
    logic go;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      fire = in_push && !in_full;
      if (fire) begin
        apply_wind_item(in_data);
        items_sent++;
        phase <= (items_sent * 3 / total_items > 2) ? 2 : items_sent * 3 / total_items;
      end
      if (!in_push || fire) begin
        go = (pending.size() > 0) && ($urandom_range(99) >= send_idle[phase]);
        if (go && pending[0].drain && expected_stats.size() != 0) go = 1'b0;
        if (go) begin
          in_data <= pending[0].item;
          void'(pending.pop_front());
        end
        in_push <= go;
      end
    end
  end

  // receiver
  always @(posedge clk) begin : monitor
    wss_pkg::out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_data.pulse_sum, 0);
        end else begin
          want = expected_stats.pop_front();
          if (out_data.pulse_sum !== want.pulse_sum)
            report_mismatch("pulse_sum", out_data.pulse_sum, want.pulse_sum);
          if (out_data.pair_peak !== want.pair_peak)
            report_mismatch("pair_peak", out_data.pair_peak, want.pair_peak);
          if (out_data.avg_speed_centi !== want.avg_speed_centi)
            report_mismatch("avg_speed_centi", out_data.avg_speed_centi,
                            want.avg_speed_centi);
          if (out_data.gust_speed_centi !== want.gust_speed_centi)
            report_mismatch("gust_speed_centi", out_data.gust_speed_centi,
                            want.gust_speed_centi);
        end
      end
      out_pop <= !hold_off && ($urandom_range(99) >= recv_idle[phase]);
    end
  end

  // long receiver hold-off so the input side backs up
  initial begin : receiver_hold
    while (items_sent < 250) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] cnt;
    logic [15:0] delta;
    bit          mid_drained;
    foreach (slot_counts[i]) slot_counts[i] = '0;
    next_slot    = 0;
    prev_counter = '0;
    mid_drained  = 1'b0;

    // reset state, then a window full of maximum differences
    add_item(wss_pkg::ACT_QUERY, 16'h0000);
    add_item(wss_pkg::ACT_START, 16'h0000);
    for (int k = 0; k < WIN; k++) add_item(wss_pkg::ACT_MINUTE, 16'(16'hFFFF - k));
    add_item(wss_pkg::ACT_QUERY, 16'hFFFF);
    // write slot wrapped to zero: overwrite it
    add_item(wss_pkg::ACT_MINUTE, 16'(16'hFFF6 - WIN + 3));
    add_item(ACT_UNUSED, 16'hFFFF);
    add_item(wss_pkg::ACT_QUERY, 16'h5555);
    // counter wrap and zero difference
    add_item(wss_pkg::ACT_START, 16'hFFFF);
    add_item(wss_pkg::ACT_MINUTE, 16'h0004);
    add_item(wss_pkg::ACT_MINUTE, 16'h0004);
    add_item(wss_pkg::ACT_QUERY, 16'hAAAA);
    add_item(ACT_UNUSED, 16'h0000);

    add_item(wss_pkg::ACT_QUERY, 16'(($urandom)), 1'b1);
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        cnt = 16'($urandom);
        add_item(wss_pkg::ACT_START, cnt);
        repeat ($urandom_range(1, 24)) begin
          case ($urandom_range(9))
            0:       delta = 16'h0000;
            1:       delta = 16'hFFFF;
            2, 3:    delta = 16'($urandom);
            default: delta = 16'($urandom_range(0, 120));
          endcase
          cnt = cnt + delta;
          add_item(wss_pkg::ACT_MINUTE, cnt);
          if ($urandom_range(99) < 35) add_item(wss_pkg::ACT_QUERY, 16'($urandom));
        end
        add_item(wss_pkg::ACT_QUERY, 16'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) add_item(2'($urandom_range(0, 3)), 16'($urandom));
      end
      if (!mid_drained && counted >= RANDOM_ITEMS / 2) begin
        add_item(wss_pkg::ACT_QUERY, 16'($urandom), 1'b1);
        mid_drained = 1'b1;
      end
    end
    total_items = pending.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_push) @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
